[rtl/core/rrq_pkg.sv]
// Shared types and constants of the round-robin ready queue.
`default_nettype none

package rrq_pkg;

  // Command codes on the command port.
  localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_START    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SELECT,
    ST_READ,
    ST_POP,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture the inputs of a new transaction
    logic push_handle;   // append the captured handle
    logic push_running;  // append the current task
    logic set_drop;      // an append failed because the ring is full
    logic load_idle;     // make the idle task current
    logic pop;           // read the front slot and advance the head
    logic take_pop;      // make the slot just read current
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] command;
    logic       still_running;
    logic       running_valid;
    logic       full;
    logic       empty;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/rrq_datapath.sv]
// Datapath of the ready queue: slot memory, ring pointers, current task and flags.
`default_nettype none

module rrq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rrq_pkg::ctrl_cmd_t                 cmd,
  output rrq_pkg::dp_status_t                     status,
  input  wire logic [1:0]                         command,
  input  wire logic [HANDLE_BITS-1:0]             task_handle,
  input  wire logic                               current_running,
  input  wire logic                               idle_task_we,
  input  wire logic [HANDLE_BITS-1:0]             idle_task,
  output logic [HANDLE_BITS-1:0]                  current_task,
  output logic                                    current_valid,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        queue_count,
  output logic                                    dropped
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  logic [HANDLE_BITS-1:0] slots [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] slot_rdata;
  logic [IDX_W-1:0]       head;
  logic [IDX_W-1:0]       tail;
  logic [CNT_W-1:0]       count;
  logic [HANDLE_BITS-1:0] running_task;
  logic                   running_valid;
  logic [HANDLE_BITS-1:0] idle_reg;
  logic                   drop;
  logic [1:0]             command_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   still_running_q;
  logic                   push;
  logic [HANDLE_BITS-1:0] push_data;

  assign push      = cmd.push_handle || cmd.push_running;
  assign push_data = cmd.push_running ? running_task : handle_q;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
    if (cmd.pop) begin
      slot_rdata <= slots[head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command_q       <= command;
      handle_q        <= task_handle;
      still_running_q <= current_running;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      count         <= '0;
      running_task  <= '0;
      running_valid <= 1'b0;
      idle_reg      <= '0;
      drop          <= 1'b0;
    end else begin
      if (idle_task_we) begin
        idle_reg <= idle_task;
      end
      if (cmd.load) begin
        drop <= 1'b0;
      end else if (cmd.set_drop) begin
        drop <= 1'b1;
      end
      if (push) begin
        tail  <= (tail == LAST_IDX) ? '0 : tail + 1'b1;
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        head  <= (head == LAST_IDX) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end
      if (cmd.load_idle) begin
        running_task  <= idle_reg;
        running_valid <= 1'b1;
      end else if (cmd.take_pop) begin
        running_task  <= slot_rdata;
        running_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    status.command       = command_q;
    status.still_running = still_running_q;
    status.running_valid = running_valid;
    status.full          = (count == FULL_CNT);
    status.empty         = (count == '0);
  end

  assign current_task  = running_task;
  assign current_valid = running_valid;
  assign queue_count   = count;
  assign dropped       = drop;

endmodule

`default_nettype wire

[rtl/core/rrq_ctrl.sv]
// Controller state machine that sequences each command of the ready queue.
`default_nettype none

module rrq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire rrq_pkg::dp_status_t status,
  output rrq_pkg::ctrl_cmd_t       cmd,
  output logic                     busy,
  output logic                     done
);

  rrq_pkg::state_t state;
  rrq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      rrq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rrq_pkg::ST_EXEC;
        end
      end
      rrq_pkg::ST_EXEC: begin
        case (status.command)
          rrq_pkg::CMD_ENQUEUE: begin
            if (status.full) begin
              cmd.set_drop = 1'b1;
            end else begin
              cmd.push_handle = 1'b1;
            end
            state_next = rrq_pkg::ST_RESP;
          end
          rrq_pkg::CMD_SCHEDULE: begin
            // The current task goes to the back before the front is taken.
            if (status.running_valid && status.still_running) begin
              if (status.full) begin
                cmd.set_drop = 1'b1;
              end else begin
                cmd.push_running = 1'b1;
              end
            end
            state_next = rrq_pkg::ST_SELECT;
          end
          rrq_pkg::CMD_START: begin
            state_next = status.empty ? rrq_pkg::ST_RESP : rrq_pkg::ST_READ;
          end
          default: begin
            state_next = rrq_pkg::ST_RESP;
          end
        endcase
      end
      rrq_pkg::ST_SELECT: begin
        if (status.empty) begin
          cmd.load_idle = 1'b1;
          state_next    = rrq_pkg::ST_RESP;
        end else begin
          state_next = rrq_pkg::ST_READ;
        end
      end
      rrq_pkg::ST_READ: begin
        cmd.pop    = 1'b1;
        state_next = rrq_pkg::ST_POP;
      end
      rrq_pkg::ST_POP: begin
        cmd.take_pop = 1'b1;
        state_next   = rrq_pkg::ST_RESP;
      end
      rrq_pkg::ST_RESP: begin
        done       = 1'b1;
        state_next = rrq_pkg::ST_IDLE;
      end
      default: begin
        state_next = rrq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/round_robin_ready_queue_unit.sv]
// Top level of the round-robin ready queue task scheduler.
//
// A transaction is taken when start is high while busy is low; its result
// (current task, valid flag, queue count and drop flag) is shown for exactly
// one cycle with done high, and the receiver cannot stall it. From start, an
// enqueue, an unused code or start on an empty queue pass EXEC and RESP;
// schedule onto the idle task EXEC, SELECT and RESP; start with a pop EXEC,
// READ, POP and RESP; schedule with a pop EXEC, SELECT, READ, POP and RESP,
// as the state machine steps through an append and then a pop of the slot
// memory, whose read data is registered. idle_task is to be written by
// idle_task_we only while the block is idle; the block does not enforce this.
`default_nettype none

module round_robin_ready_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         command,
  input  wire logic [HANDLE_BITS-1:0]             task_handle,
  input  wire logic                               current_running,
  input  wire logic                               idle_task_we,
  input  wire logic [HANDLE_BITS-1:0]             idle_task,
  output logic                                    done,
  output logic [HANDLE_BITS-1:0]                  current_task,
  output logic                                    current_valid,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        queue_count,
  output logic                                    dropped
);

  rrq_pkg::ctrl_cmd_t  cmd;
  rrq_pkg::dp_status_t status;

  rrq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rrq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .command         (command),
    .task_handle     (task_handle),
    .current_running (current_running),
    .idle_task_we    (idle_task_we),
    .idle_task       (idle_task),
    .current_task    (current_task),
    .current_valid   (current_valid),
    .queue_count     (queue_count),
    .dropped         (dropped)
  );

endmodule

`default_nettype wire

[tb/sv/tb_round_robin_ready_queue_unit.sv]
// Self-checking testbench of the round-robin ready queue unit, with a built-in predictor.
`timescale 1ns / 100ps

module tb_round_robin_ready_queue_unit;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RING_DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 225;

  typedef struct {
    logic [1:0]  command;
    logic [15:0] handle;
    logic        running;
  } sched_cmd_t;

  typedef struct {
    logic [15:0] task_id;
    logic        valid;
    logic [4:0]  count;
    logic        drop;
  } sched_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  command = rrq_pkg::CMD_ENQUEUE;
  logic [15:0] task_handle = '0;
  logic        current_running = 1'b0;
  logic        idle_task_we = 1'b0;
  logic [15:0] idle_task = '0;
  logic        busy;
  logic        done;
  logic [15:0] current_task;
  logic        current_valid;
  logic [4:0]  queue_count;
  logic        dropped;

  // Predictor state.
  logic [15:0] ring_slot [RING_DEPTH];
  logic [3:0]  ring_head = '0;
  logic [3:0]  ring_tail = '0;
  logic [4:0]  ring_count = '0;
  logic [15:0] cur_task = '0;
  logic        cur_valid = 1'b0;
  logic [15:0] sleep_handle = '0;

  sched_cmd_t    cmd_backlog [$];
  sched_status_t predicted_status [$];
  sched_cmd_t    issued;
  int            idle_pct = 0;
  int            items_total = 0;
  int            results_seen = 0;
  int            errors = 0;
  int            quiet_cycles = 0;

  round_robin_ready_queue_unit #(
    .QUEUE_DEPTH(RING_DEPTH),
    .HANDLE_BITS(16)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .task_handle(task_handle),
    .current_running(current_running),
    .idle_task_we(idle_task_we),
    .idle_task(idle_task),
    .done(done),
    .current_task(current_task),
    .current_valid(current_valid),
    .queue_count(queue_count),
    .dropped(dropped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit ring_append(input logic [15:0] h);
    if (ring_count >= RING_DEPTH) return 1'b0;
    ring_slot[ring_tail] = h;
    ring_tail = ring_tail + 4'd1;
    ring_count = ring_count + 5'd1;
    return 1'b1;
  endfunction

  function automatic logic [15:0] ring_take();
    logic [15:0] h;
    h = ring_slot[ring_head];
    ring_head = ring_head + 4'd1;
    ring_count = ring_count - 5'd1;
    return h;
  endfunction

  // Applies one command to the predicted scheduler state and returns what it reports.
  function automatic sched_status_t advance_scheduler(input sched_cmd_t c);
    sched_status_t r;
    logic drop;
    drop = 1'b0;
    case (c.command)
      rrq_pkg::CMD_ENQUEUE: drop = !ring_append(c.handle);
      rrq_pkg::CMD_SCHEDULE: begin
        // A task that is still running goes back to the tail before the pop.
        if (cur_valid && c.running) drop = !ring_append(cur_task);
        if (ring_count == 0) cur_task = sleep_handle;
        else cur_task = ring_take();
        cur_valid = 1'b1;
      end
      rrq_pkg::CMD_START: begin
        if (ring_count != 0) begin
          cur_task = ring_take();
          cur_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.task_id = cur_task;
    r.valid = cur_valid;
    r.count = ring_count;
    r.drop = drop;
    return r;
  endfunction

  function automatic void queue_cmd(input logic [1:0] c, input logic [15:0] h, input logic run);
    sched_cmd_t item;
    item.command = c;
    item.handle = h;
    item.running = run;
    cmd_backlog.push_back(item);
    items_total++;
  endfunction

  // Driver: predicts each accepted transaction and presents the next one.
  always @(posedge clk) begin : drive_proc
    logic taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) predicted_status.push_back(advance_scheduler(issued));
      if (start && !taken) begin
        // Hold the transaction until the block takes it.
      end else if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        issued = cmd_backlog.pop_front();
        start <= 1'b1;
        command <= issued.command;
        task_handle <= issued.handle;
        current_running <= issued.running;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each result is compared with the oldest prediction.
  always @(posedge clk) begin : check_proc
    sched_status_t want;
    if (!rst && done) begin
      results_seen++;
      if (predicted_status.size() == 0) begin
        $error("result with no transaction outstanding: current_task %h", current_task);
        errors++;
      end else begin
        want = predicted_status.pop_front();
        if (current_task !== want.task_id) begin
          $error("current_task expected %h actual %h", want.task_id, current_task);
          errors++;
        end
        if (current_valid !== want.valid) begin
          $error("current_valid expected %b actual %b", want.valid, current_valid);
          errors++;
        end
        if (queue_count !== want.count) begin
          $error("queue_count expected %0d actual %0d", want.count, queue_count);
          errors++;
        end
        if (dropped !== want.drop) begin
          $error("dropped expected %b actual %b", want.drop, dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (results_seen < items_total) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_sleep_handle(input logic [15:0] v);
    @(posedge clk);
    idle_task_we <= 1'b1;
    idle_task <= v;
    sleep_handle = v;
    @(posedge clk);
    idle_task_we <= 1'b0;
  endtask

  initial begin : stimulus_proc
    logic [15:0] phase_sleep [4];
    int phase_idle [4];
    int n, burst, mode, roll, enq_lim, sch_lim, pick;
    logic [1:0] c;
    logic [15:0] h;

    phase_sleep[0] = 16'hFFFF;
    phase_sleep[1] = 16'($urandom_range(65535));
    phase_sleep[2] = 16'h0000;
    phase_sleep[3] = 16'($urandom_range(65535));
    phase_idle[0] = 0;
    phase_idle[1] = 71;
    phase_idle[2] = 0;
    phase_idle[3] = 11;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_sleep_handle(16'hA5C3);

    // Directed part: empty-queue corners, fill to full, overflow on both append paths.
    queue_cmd(rrq_pkg::CMD_START, 16'h0000, 1'b0);
    queue_cmd(rrq_pkg::CMD_SCHEDULE, 16'h0000, 1'b1);
    queue_cmd(rrq_pkg::CMD_SCHEDULE, 16'h0000, 1'b1);
    queue_cmd(rrq_pkg::CMD_ENQUEUE, 16'h0000, 1'b0);
    queue_cmd(rrq_pkg::CMD_ENQUEUE, 16'hFFFF, 1'b1);
    for (int k = 0; k < 14; k++) queue_cmd(rrq_pkg::CMD_ENQUEUE, 16'h0001 << k, k[0]);
    queue_cmd(rrq_pkg::CMD_ENQUEUE, 16'h1234, 1'b0);
    queue_cmd(rrq_pkg::CMD_SCHEDULE, 16'hFFFF, 1'b1);
    queue_cmd(rrq_pkg::CMD_SCHEDULE, 16'h0000, 1'b0);
    queue_cmd(rrq_pkg::CMD_START, 16'hFFFF, 1'b1);
    queue_cmd(CMD_UNUSED, 16'hFFFF, 1'b1);
    queue_cmd(rrq_pkg::CMD_ENQUEUE, 16'hBEEF, 1'b0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_sleep_handle(phase_sleep[p]);
      idle_pct = phase_idle[p];
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        // Bursts that lean toward filling, draining or neither move the queue level around.
        mode = $urandom_range(2);
        burst = $urandom_range(30, 8);
        enq_lim = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
        sch_lim = enq_lim + ((mode == 1) ? 45 : 30);
        for (int k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
          roll = $urandom_range(99);
          if (roll >= 97) c = CMD_UNUSED;
          else if (roll < enq_lim) c = rrq_pkg::CMD_ENQUEUE;
          else if (roll < sch_lim) c = rrq_pkg::CMD_SCHEDULE;
          else c = rrq_pkg::CMD_START;
          pick = $urandom_range(9);
          h = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(65535));
          queue_cmd(c, h, $urandom_range(99) < 60);
          n++;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
